// File: rtl/clc_pkg.sv
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types, codes and the sequencer program of the character display
// line controller.
// ----------------------------------------------------------------------------
package clc_pkg;

    // Item modes
    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_TEXT  = 2'd2;

    // Transfer kinds
    localparam logic [1:0] KIND_PAUSE  = 2'd0;
    localparam logic [1:0] KIND_NIBBLE = 2'd1;
    localparam logic [1:0] KIND_BYTE   = 2'd2;

    // Display codes
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
    localparam logic [7:0] ROW1_OFFSET   = 8'h40;
    localparam logic [7:0] NIB_WAKE      = 8'h03;
    localparam logic [7:0] NIB_FOUR_BIT  = 8'h02;
    localparam logic [7:0] SPACE_CHAR    = 8'h20;

    // Program layout
    localparam int          PC_W        = 4;
    localparam logic [PC_W-1:0] STEP_INIT   = 4'd0;
    localparam logic [PC_W-1:0] STEP_CLEAR  = 4'd9;
    localparam logic [PC_W-1:0] STEP_REDRAW = 4'd10;
    localparam logic [PC_W-1:0] STEP_DATA1  = 4'd13;
    localparam logic [PC_W-1:0] STEP_COUNT  = 4'd14;

    typedef struct packed {
        logic [1:0] mode;
        logic       row;
        logic [7:0] char_code;
        logic       text_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic        reg_select;
        logic [7:0]  value;
        logic [14:0] wait_us;
        logic        last;
    } t_out_item;

    // One control word of the sequencer program
    typedef struct packed {
        logic [1:0]  kind;
        logic        reg_select;
        logic        from_ram;   // value comes from the line store
        logic [7:0]  value;
        logic [14:0] wait_us;
        logic        last;       // final transfer of the item
        logic        loop;       // repeat over all columns of a row
        logic        done;       // end of program
    } t_ctl_word;

    function automatic t_ctl_word seq_rom(input logic [PC_W-1:0] pc);
        t_ctl_word w;
        w = '0;
        unique case (pc)
            4'd0:  w = '{KIND_PAUSE,  1'b0, 1'b0, 8'h00,         15'd20000, 1'b0, 1'b0, 1'b0};
            4'd1:  w = '{KIND_NIBBLE, 1'b0, 1'b0, NIB_WAKE,      15'd5000,  1'b0, 1'b0, 1'b0};
            4'd2:  w = '{KIND_NIBBLE, 1'b0, 1'b0, NIB_WAKE,      15'd200,   1'b0, 1'b0, 1'b0};
            4'd3:  w = '{KIND_NIBBLE, 1'b0, 1'b0, NIB_WAKE,      15'd200,   1'b0, 1'b0, 1'b0};
            4'd4:  w = '{KIND_NIBBLE, 1'b0, 1'b0, NIB_FOUR_BIT,  15'd0,     1'b0, 1'b0, 1'b0};
            4'd5:  w = '{KIND_BYTE,   1'b0, 1'b0, CMD_FUNC_SET,  15'd50,    1'b0, 1'b0, 1'b0};
            4'd6:  w = '{KIND_BYTE,   1'b0, 1'b0, CMD_DISP_OFF,  15'd50,    1'b0, 1'b0, 1'b0};
            4'd7:  w = '{KIND_BYTE,   1'b0, 1'b0, CMD_ENTRY,     15'd50,    1'b0, 1'b0, 1'b0};
            4'd8:  w = '{KIND_BYTE,   1'b0, 1'b0, CMD_DISP_ON,   15'd50,    1'b0, 1'b0, 1'b0};
            4'd9:  w = '{KIND_BYTE,   1'b0, 1'b0, CMD_CLEAR,     15'd2000,  1'b1, 1'b0, 1'b1};
            4'd10: w = '{KIND_BYTE,   1'b0, 1'b0, CMD_SET_ADDR,  15'd50,    1'b0, 1'b0, 1'b0};
            4'd11: w = '{KIND_BYTE,   1'b1, 1'b1, 8'h00,         15'd50,    1'b0, 1'b1, 1'b0};
            4'd12: w = '{KIND_BYTE,   1'b0, 1'b0, CMD_SET_ADDR | ROW1_OFFSET,
                         15'd50, 1'b0, 1'b0, 1'b0};
            4'd13: w = '{KIND_BYTE,   1'b1, 1'b1, 8'h00,         15'd50,    1'b1, 1'b1, 1'b1};
            default: w = '{KIND_PAUSE, 1'b0, 1'b0, 8'h00, 15'd0, 1'b1, 1'b0, 1'b1};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/clc_ram.sv
// ----------------------------------------------------------------------------
// clc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module clc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write when enabled, read each cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/char_lcd_line_controller.sv
// ----------------------------------------------------------------------------
// char_lcd_line_controller
// Two-line character display controller for a 4-bit bus, driven by a small
// microcoded sequencer over a line store.
// ----------------------------------------------------------------------------
// An init item yields 10 transfers, a clear item 1, and the last item of a
// text 2*LINE_CHARS+2 transfers (one set-address command and LINE_CHARS data
// bytes per row); other text items and unused modes yield none. Transfers
// leave one per clock while the output is not stalled: the sequencer steps
// once per cycle into a single output register, and the line store is read
// a step ahead so that its data is ready when the step comes. No new item
// is taken while the sequencer runs. The line store needs no clearing pass;
// blanking is done with per-entry valid bits, so init, clear and a new text
// act at once.
// ----------------------------------------------------------------------------
module char_lcd_line_controller #(
    parameter int LINE_CHARS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  clc_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output clc_pkg::t_out_item o_out
);

    localparam int DEPTH = 2 * LINE_CHARS;
    localparam int AW    = $clog2(DEPTH);
    localparam int COL_W = $clog2(LINE_CHARS);
    localparam int POS_W = $clog2(LINE_CHARS + 1);
    localparam logic [DEPTH-1:0] ROW0_MASK = DEPTH'({LINE_CHARS{1'b1}});

    // Map row and column onto a line store address
    function automatic logic [AW-1:0] store_addr(input logic row, input logic [COL_W-1:0] col);
        return row ? (AW'(LINE_CHARS) + AW'(col)) : AW'(col);
    endfunction

    // Sequencer
    logic [clc_pkg::PC_W-1:0] r_pc, n_pc;
    logic [COL_W-1:0]         r_col, n_col;
    logic                     r_busy, n_busy;

    // Text state
    logic                     r_open, n_open;
    logic                     r_stop, n_stop;
    logic                     r_row, n_row;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic [DEPTH-1:0]         r_vld, n_vld;

    // Output register
    logic                     r_out_valid;
    clc_pkg::t_out_item       r_out, item;

    clc_pkg::t_ctl_word       ctl;
    logic                     in_acc, advance, col_end, step_last;
    logic                     eff_row, store_we;
    logic [AW-1:0]            waddr, raddr, cur_addr;
    logic [7:0]               rdata;
    logic [DEPTH-1:0]         row_mask;

    clc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (waddr),
        .i_wdata (i_in.char_code),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Step the program and apply accepted items
    always_comb begin
        ctl       = clc_pkg::seq_rom(r_pc);
        in_acc    = i_in_valid && !r_busy;
        advance   = r_busy && (!r_out_valid || !i_out_stall);
        col_end   = (r_col == COL_W'(LINE_CHARS - 1));
        step_last = ctl.loop ? col_end : 1'b1;

        n_pc   = r_pc;
        n_col  = r_col;
        n_busy = r_busy;
        n_open = r_open;
        n_stop = r_stop;
        n_row  = r_row;
        n_pos  = r_pos;
        n_vld  = r_vld;

        eff_row  = r_open ? r_row : i_in.row;
        row_mask = eff_row ? (ROW0_MASK << LINE_CHARS) : ROW0_MASK;
        waddr    = store_addr(eff_row, r_open ? r_pos[COL_W-1:0] : '0);
        store_we = 1'b0;

        // Advance the step counter
        if (advance) begin
            if (ctl.loop && !col_end) begin
                n_col = r_col + COL_W'(1);
            end else begin
                n_col = '0;
                n_pc  = r_pc + clc_pkg::PC_W'(1);
            end
            if (ctl.done && step_last) begin
                n_busy = 1'b0;
            end
        end

        // Take a new item
        if (in_acc) begin
            unique case (i_in.mode)
                clc_pkg::MODE_INIT, clc_pkg::MODE_CLEAR: begin
                    n_vld  = '0;
                    n_open = 1'b0;
                    n_stop = 1'b0;
                    n_row  = 1'b0;
                    n_pos  = '0;
                    n_busy = 1'b1;
                    n_col  = '0;
                    n_pc   = (i_in.mode == clc_pkg::MODE_INIT) ? clc_pkg::STEP_INIT
                                                               : clc_pkg::STEP_CLEAR;
                end
                clc_pkg::MODE_TEXT: begin
                    // Open the text: latch row, blank it
                    if (!r_open) begin
                        n_open = 1'b1;
                        n_stop = 1'b0;
                        n_row  = i_in.row;
                        n_pos  = '0;
                        n_vld  = r_vld & ~row_mask;
                    end
                    if (!(r_open && r_stop)) begin
                        if (i_in.char_code == 8'h00 ||
                            (r_open && r_pos >= POS_W'(LINE_CHARS))) begin
                            n_stop = 1'b1;
                        end else begin
                            store_we     = 1'b1;
                            n_vld[waddr] = 1'b1;
                            n_pos        = (r_open ? r_pos : '0) + POS_W'(1);
                        end
                    end
                    if (i_in.text_end) begin
                        n_open = 1'b0;
                        n_stop = 1'b0;
                        n_row  = 1'b0;
                        n_pos  = '0;
                        n_busy = 1'b1;
                        n_col  = '0;
                        n_pc   = clc_pkg::STEP_REDRAW;
                    end
                end
                default: begin
                end
            endcase
        end

        // Read one step ahead so data is ready when its step comes
        raddr    = store_addr(n_pc == clc_pkg::STEP_DATA1, n_col);
        cur_addr = store_addr(r_pc == clc_pkg::STEP_DATA1, r_col);

        item.kind       = ctl.kind;
        item.reg_select = ctl.reg_select;
        item.value      = ctl.from_ram ? (r_vld[cur_addr] ? rdata : clc_pkg::SPACE_CHAR)
                                       : ctl.value;
        item.wait_us    = ctl.wait_us;
        item.last       = ctl.last && step_last;
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_col       <= '0;
            r_busy      <= 1'b0;
            r_open      <= 1'b0;
            r_stop      <= 1'b0;
            r_row       <= 1'b0;
            r_pos       <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_col  <= n_col;
            r_busy <= n_busy;
            r_open <= n_open;
            r_stop <= n_stop;
            r_row  <= n_row;
            r_pos  <= n_pos;
            r_vld  <= n_vld;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out <= item;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc < clc_pkg::STEP_COUNT))
        else $error("sequencer step out of program");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(LINE_CHARS))
        else $error("write position past row end");

    a_init_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.mode == clc_pkg::MODE_INIT) |=>
            (r_busy && r_pc == clc_pkg::STEP_INIT && r_vld == '0))
        else $error("init item did not start the program");

    a_redraw_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.mode == clc_pkg::MODE_TEXT && i_in.text_end) |=>
            (r_busy && !r_open && r_pc == clc_pkg::STEP_REDRAW))
        else $error("text end did not start a redraw");

endmodule
